// ===== rtl/lpfd_pkg.sv =====
// lpfd_pkg: shared types and constants of the length-prefixed frame deframer
// no dependencies; imported by every rtl module of the block

package lpfd_pkg;

    localparam int HDR_BYTES = 16;
    localparam int HDR_BITS  = HDR_BYTES * 8;
    localparam int CNT_W     = $clog2(HDR_BYTES);

    localparam logic [CNT_W-1:0] HDR_LAST = CNT_W'(HDR_BYTES - 1);

    localparam logic [31:0] RST_MAGIC   = 32'h4832_3634;
    localparam logic [15:0] RST_VERSION = 16'd1;
    localparam logic [15:0] RST_TYPE    = 16'd1;
    localparam logic [31:0] RST_MAX_LEN = 32'd8388608;

    localparam logic [1:0] CFG_MAGIC   = 2'd0;
    localparam logic [1:0] CFG_VERSION = 2'd1;
    localparam logic [1:0] CFG_TYPE    = 2'd2;
    localparam logic [1:0] CFG_MAX_LEN = 2'd3;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_ERROR   = 1'b1;

    localparam logic [2:0] ERR_MAGIC   = 3'd0;
    localparam logic [2:0] ERR_VERSION = 3'd1;
    localparam logic [2:0] ERR_TYPE    = 3'd2;
    localparam logic [2:0] ERR_ZERO    = 3'd3;
    localparam logic [2:0] ERR_LONG    = 3'd4;
    localparam logic [2:0] ERR_NONE    = 3'd0;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_DROP    = 3'b100
    } t_phase;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] ptype;
        logic [31:0] max_len;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic        last;
        logic [31:0] sequence_res;
        logic        sequence_warning;
        logic [2:0]  fault_code;
    } t_res;

endpackage

// ===== rtl/lpfd_front.sv =====
// lpfd_front: header gathering, header checks and payload tagging
// depends on lpfd_pkg; feeds one result per accepted transaction at most

module lpfd_front
    import lpfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_operation,
    input  logic [7:0] i_data_byte,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_res       o_res
);

    t_phase                r_phase, n_phase;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [HDR_BITS-9:0]   r_hdr, n_hdr;
    logic [31:0]           r_rem, n_rem;
    logic [31:0]           r_cur_seq, n_cur_seq;
    logic [31:0]           r_seq_next, n_seq_next;
    logic                  r_warn, n_warn;
    logic                  r_seq_valid, n_seq_valid;

    logic [HDR_BITS-1:0]   hdr_full;
    logic [31:0]           hdr_magic, hdr_len, hdr_seq;
    logic [15:0]           hdr_ver, hdr_type;
    logic                  hdr_bad;
    logic [2:0]            hdr_err;

    assign hdr_full  = {r_hdr, i_data_byte};
    assign hdr_magic = hdr_full[127:96];
    assign hdr_ver   = hdr_full[95:80];
    assign hdr_type  = hdr_full[79:64];
    assign hdr_len   = hdr_full[63:32];
    assign hdr_seq   = hdr_full[31:0];

    // first failing check wins
    always_comb begin
        hdr_bad = 1'b1;
        hdr_err = ERR_NONE;
        if (hdr_magic != i_cfg.magic) begin
            hdr_err = ERR_MAGIC;
        end else if (hdr_ver != i_cfg.version) begin
            hdr_err = ERR_VERSION;
        end else if (hdr_type != i_cfg.ptype) begin
            hdr_err = ERR_TYPE;
        end else if (hdr_len == 32'd0) begin
            hdr_err = ERR_ZERO;
        end else if (hdr_len > i_cfg.max_len) begin
            hdr_err = ERR_LONG;
        end else begin
            hdr_bad = 1'b0;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_hdr       = r_hdr;
        n_rem       = r_rem;
        n_cur_seq   = r_cur_seq;
        n_seq_next  = r_seq_next;
        n_warn      = r_warn;
        n_seq_valid = r_seq_valid;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            if (i_operation == OP_START) begin
                n_phase     = PH_HEADER;
                n_cnt       = '0;
                n_rem       = '0;
                n_warn      = 1'b0;
                n_seq_valid = 1'b0;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        n_hdr = hdr_full[HDR_BITS-9:0];
                        if (r_cnt == HDR_LAST) begin
                            n_cnt = '0;
                            if (hdr_bad) begin
                                n_phase          = PH_DROP;
                                o_res_valid      = 1'b1;
                                o_res.kind       = KIND_ERROR;
                                o_res.fault_code = hdr_err;
                            end else begin
                                n_warn      = r_seq_valid && (hdr_seq != r_seq_next);
                                n_seq_next  = hdr_seq + 32'd1;
                                n_seq_valid = 1'b1;
                                n_cur_seq   = hdr_seq;
                                n_rem       = hdr_len;
                                n_phase     = PH_PAYLOAD;
                            end
                        end else begin
                            n_cnt = r_cnt + CNT_W'(1);
                        end
                    end
                    PH_PAYLOAD: begin
                        o_res_valid            = 1'b1;
                        o_res.kind             = KIND_PAYLOAD;
                        o_res.payload_byte     = i_data_byte;
                        o_res.last             = (r_rem <= 32'd1);
                        o_res.sequence_res     = r_cur_seq;
                        o_res.sequence_warning = r_warn;
                        if (r_rem <= 32'd1) begin
                            n_rem   = '0;
                            n_phase = PH_HEADER;
                        end else begin
                            n_rem = r_rem - 32'd1;
                        end
                    end
                    PH_DROP: begin
                        n_phase = PH_DROP;
                    end
                    default: begin
                        n_phase = PH_HEADER;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_cnt       <= '0;
            r_rem       <= '0;
            r_warn      <= 1'b0;
            r_seq_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_rem       <= n_rem;
            r_warn      <= n_warn;
            r_seq_valid <= n_seq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr      <= n_hdr;
        r_cur_seq  <= n_cur_seq;
        r_seq_next <= n_seq_next;
    end

endmodule

// ===== rtl/lpfd_queue.sv =====
// lpfd_queue: short result queue between the parser and the result side
// depends on lpfd_pkg for the result type

module lpfd_queue
    import lpfd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_res o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_res             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/length_prefixed_frame_deframer_top.sv =====
// length_prefixed_frame_deframer_top: byte stream deframer, config registers
// depends on lpfd_pkg, lpfd_front and lpfd_queue
//
//  channel   handshake          payload
//  input     push / full        i_operation, i_data_byte
//  result    empty / pop        o_kind .. o_fault_code
//  config    i_cfg_we           i_cfg_idx, i_cfg_data
//
// one byte per clock while full is low; the parser handles a transaction in the cycle it is taken
// a result is poppable in the cycle after its input transaction
// full follows the result queue (QUEUE_DEPTH entries), so a stalled pop holds
// the input off only once the queue has filled
// synchronous active-low reset; parser, queue and registers come up at once

module length_prefixed_frame_deframer_top
    import lpfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_operation,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_last,
    output logic [31:0] o_sequence_res,
    output logic        o_sequence_warning,
    output logic [2:0]  o_fault_code,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_cfg r_cfg;
    t_res front_res;
    t_res head;
    logic front_valid;
    logic accept;

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic   <= RST_MAGIC;
            r_cfg.version <= RST_VERSION;
            r_cfg.ptype   <= RST_TYPE;
            r_cfg.max_len <= RST_MAX_LEN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAGIC:   r_cfg.magic   <= i_cfg_data;
                CFG_VERSION: r_cfg.version <= i_cfg_data[15:0];
                CFG_TYPE:    r_cfg.ptype   <= i_cfg_data[15:0];
                CFG_MAX_LEN: r_cfg.max_len <= i_cfg_data;
                default:     r_cfg.magic   <= r_cfg.magic;
            endcase
        end
    end

    lpfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_operation (i_operation),
        .i_data_byte (i_data_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (front_valid),
        .o_res       (front_res)
    );

    lpfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_res),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (head)
    );

    assign o_kind             = head.kind;
    assign o_payload_byte     = head.payload_byte;
    assign o_last             = head.last;
    assign o_sequence_res     = head.sequence_res;
    assign o_sequence_warning = head.sequence_warning;
    assign o_fault_code       = head.fault_code;

endmodule

// ===== rtl/lpfd_checker.sv =====
// lpfd_checker: port-level assertions on the deframer top level
// depends on lpfd_pkg; bound to length_prefixed_frame_deframer_top below

module lpfd_checker
    import lpfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        i_operation,
    input  logic        empty,
    input  logic        pop,
    input  logic        o_kind,
    input  logic [7:0]  o_payload_byte,
    input  logic        o_last,
    input  logic [31:0] o_sequence_res,
    input  logic        o_sequence_warning,
    input  logic [2:0]  o_fault_code
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> (empty && !full))
        else $error("queue not empty after reset");

    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(full && empty))
        else $error("full and empty together");

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_ERROR) |->
        (o_payload_byte == 8'd0 && !o_last && o_sequence_res == 32'd0
         && !o_sequence_warning
         && (o_fault_code == ERR_MAGIC || o_fault_code == ERR_VERSION
             || o_fault_code == ERR_TYPE || o_fault_code == ERR_ZERO
             || o_fault_code == ERR_LONG)))
        else $error("malformed error result");

    a_payload_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_PAYLOAD) |-> (o_fault_code == ERR_NONE))
        else $error("payload result with fault code");

    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && i_operation == OP_START && empty) |=> empty)
        else $error("connection start produced a result");

endmodule

bind length_prefixed_frame_deframer_top lpfd_checker u_lpfd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .push               (push),
    .full               (full),
    .i_operation        (i_operation),
    .empty              (empty),
    .pop                (pop),
    .o_kind             (o_kind),
    .o_payload_byte     (o_payload_byte),
    .o_last             (o_last),
    .o_sequence_res     (o_sequence_res),
    .o_sequence_warning (o_sequence_warning),
    .o_fault_code       (o_fault_code)
);

// ===== test/lpfd_stream_checker.sv =====
// lpfd_stream_checker: watches the input, result and config channels of the deframer,
// predicts each result and compares it field by field with the popped transaction
// depends on lpfd_pkg; instantiated beside the block by the testbench top

module lpfd_stream_checker
    import lpfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic        i_operation,
    input  logic [7:0]  i_data_byte,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_kind,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_last,
    input  logic [31:0] i_sequence_res,
    input  logic        i_sequence_warning,
    input  logic [2:0]  i_fault_code,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_outstanding
);

    t_cfg        cfg;
    t_phase      frm_phase;
    logic [7:0]  hdr [HDR_BYTES];
    int          hdr_cnt;
    logic [31:0] bytes_left;
    logic [31:0] cur_seq;
    logic [31:0] last_seq;
    logic        warn_flag;
    logic        seq_seen;
    t_res        results_due [$];

    function automatic logic [31:0] hdr_word(input int at);
        return {hdr[at], hdr[at+1], hdr[at+2], hdr[at+3]};
    endfunction

    task automatic clear_tracking();
        frm_phase  = PH_HEADER;
        hdr_cnt    = 0;
        bytes_left = '0;
        warn_flag  = 1'b0;
        last_seq   = '0;
        seq_seen   = 1'b0;
    endtask

    task automatic deframe_step(input logic op, input logic [7:0] b);
        logic [31:0] len;
        logic [31:0] seq;
        logic        bad;
        t_res        r;
        r   = '0;
        bad = 1'b0;
        if (op == OP_START) begin
            clear_tracking();
        end else if (frm_phase == PH_HEADER) begin
            hdr[hdr_cnt] = b;
            hdr_cnt++;
            if (hdr_cnt == HDR_BYTES) begin
                hdr_cnt = 0;
                len     = hdr_word(8);
                seq     = hdr_word(12);
                bad     = 1'b1;
                r.kind  = KIND_ERROR;
                // first failing check wins
                if (hdr_word(0) != cfg.magic)
                    r.fault_code = ERR_MAGIC;
                else if ({hdr[4], hdr[5]} != cfg.version)
                    r.fault_code = ERR_VERSION;
                else if ({hdr[6], hdr[7]} != cfg.ptype)
                    r.fault_code = ERR_TYPE;
                else if (len == 32'd0)
                    r.fault_code = ERR_ZERO;
                else if (len > cfg.max_len)
                    r.fault_code = ERR_LONG;
                else
                    bad = 1'b0;
                if (bad) begin
                    frm_phase = PH_DROP;
                    results_due.push_back(r);
                end else begin
                    warn_flag  = seq_seen && (seq != last_seq + 32'd1);
                    last_seq   = seq;
                    seq_seen   = 1'b1;
                    cur_seq    = seq;
                    bytes_left = len;
                    frm_phase  = PH_PAYLOAD;
                end
            end
        end else if (frm_phase == PH_PAYLOAD) begin
            r.kind             = KIND_PAYLOAD;
            r.payload_byte     = b;
            r.last             = (bytes_left <= 32'd1);
            r.sequence_res     = cur_seq;
            r.sequence_warning = warn_flag;
            r.fault_code       = ERR_NONE;
            if (bytes_left > 32'd0)
                bytes_left--;
            if (bytes_left == 32'd0)
                frm_phase = PH_HEADER;
            results_due.push_back(r);
        end
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            cfg          = '{magic: RST_MAGIC, version: RST_VERSION, ptype: RST_TYPE,
                             max_len: RST_MAX_LEN};
            o_fail_count = 0;
            clear_tracking();
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAGIC:   cfg.magic   = i_cfg_data;
                    CFG_VERSION: cfg.version = i_cfg_data[15:0];
                    CFG_TYPE:    cfg.ptype   = i_cfg_data[15:0];
                    CFG_MAX_LEN: cfg.max_len = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none actual kind %0h",
                             $time, i_kind);
                    o_fail_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("kind", 32'(want.kind), 32'(i_kind));
                    check_field("payload_byte", 32'(want.payload_byte), 32'(i_payload_byte));
                    check_field("last", 32'(want.last), 32'(i_last));
                    check_field("sequence_res", want.sequence_res, i_sequence_res);
                    check_field("sequence_warning", 32'(want.sequence_warning),
                                32'(i_sequence_warning));
                    check_field("fault_code", 32'(want.fault_code), 32'(i_fault_code));
                end
            end
            if (i_push && !i_full)
                deframe_step(i_operation, i_data_byte);
        end
        o_outstanding = results_due.size();
    end

endmodule

// ===== test/length_prefixed_frame_deframer_top_tb.sv =====
// length_prefixed_frame_deframer_top_tb: drives framed byte streams and config phases
// into the deframer with random idling on both sides; verdict from lpfd_stream_checker
// depends on lpfd_pkg, lpfd_stream_checker and the length_prefixed_frame_deframer_top rtl

module length_prefixed_frame_deframer_top_tb;
    import lpfd_pkg::*;

    localparam int ITEM_TARGET = 1900;
    localparam int PHASES      = 8;
    localparam int CYCLE_LIMIT = 1000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_operation;
    logic [7:0]  i_data_byte;
    logic        empty;
    logic        pop;
    logic        o_kind;
    logic [7:0]  o_payload_byte;
    logic        o_last;
    logic [31:0] o_sequence_res;
    logic        o_sequence_warning;
    logic [2:0]  o_fault_code;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    int          fail_count;
    int          outstanding;
    int          cycle_count;
    int          items_sent;
    bit          calm;
    bit          rx_hold_req;
    int          rx_hold_left;
    int          rx_gap;

    logic [31:0] cfg_magic;
    logic [15:0] cfg_version;
    logic [15:0] cfg_type;
    logic [31:0] cfg_max;
    logic [31:0] seq_next;

    length_prefixed_frame_deframer_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_operation        (i_operation),
        .i_data_byte        (i_data_byte),
        .empty              (empty),
        .pop                (pop),
        .o_kind             (o_kind),
        .o_payload_byte     (o_payload_byte),
        .o_last             (o_last),
        .o_sequence_res     (o_sequence_res),
        .o_sequence_warning (o_sequence_warning),
        .o_fault_code       (o_fault_code),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data)
    );

    lpfd_stream_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .i_full             (full),
        .i_operation        (i_operation),
        .i_data_byte        (i_data_byte),
        .i_empty            (empty),
        .i_pop              (pop),
        .i_kind             (o_kind),
        .i_payload_byte     (o_payload_byte),
        .i_last             (o_last),
        .i_sequence_res     (o_sequence_res),
        .i_sequence_warning (o_sequence_warning),
        .i_fault_code       (o_fault_code),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .o_fail_count       (fail_count),
        .o_outstanding      (outstanding)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("length_prefixed_frame_deframer_top_tb NOT OK");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none in calm phases
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (rx_hold_req) begin
                rx_hold_req  = 1'b0;
                rx_hold_left = 300;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                pop <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                rx_gap = idle_len();
            end
        end
    end

    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        push        <= 1'b1;
        i_operation <= op;
        i_data_byte <= b;
        do
            @(posedge i_clk);
        while (full);
        items_sent++;
        @(negedge i_clk);
        gap = idle_len();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_start();
        send_item(OP_START, 8'($urandom));
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_item(OP_BYTE, 8'($urandom));
    endtask

    task automatic send_header(input logic [31:0] magic, input logic [15:0] ver,
                               input logic [15:0] ptype, input logic [31:0] len,
                               input logic [31:0] seq);
        logic [127:0] hdr_bits;
        hdr_bits = {magic, ver, ptype, len, seq};
        for (int i = 0; i < HDR_BYTES; i++)
            send_item(OP_BYTE, hdr_bits[127 - 8*i -: 8]);
    endtask

    task automatic apply_config(input logic [31:0] magic, input logic [31:0] ver,
                                input logic [31:0] ptype, input logic [31:0] maxlen);
        logic [1:0]  regs [4];
        logic [31:0] vals [4];
        regs = '{CFG_MAGIC, CFG_VERSION, CFG_TYPE, CFG_MAX_LEN};
        vals = '{magic, ver, ptype, maxlen};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[i];
            i_cfg_data <= vals[i];
            @(negedge i_clk);
        end
        i_cfg_we    <= 1'b0;
        cfg_magic   = magic;
        cfg_version = ver[15:0];
        cfg_type    = ptype[15:0];
        cfg_max     = maxlen;
    endtask

    // stop offering before waiting, so nothing new goes in while draining
    task automatic wait_drained();
        push <= 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [31:0] good_len();
        logic [31:0] lim;
        lim = (cfg_max > 32'd24) ? 32'd24 : cfg_max;
        if ($urandom_range(0, 99) < 85 && lim > 32'd6)
            lim = 32'd6;
        return $urandom_range(1, lim);
    endfunction

    function automatic logic [31:0] pick_seq();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return seq_next;
        if (r < 92)
            return $urandom;
        return 32'hFFFF_FFFF;
    endfunction

    task automatic send_random_frame();
        int          pick;
        logic [31:0] len;
        logic [31:0] seq;
        pick = $urandom_range(0, 99);
        seq  = pick_seq();
        if (pick < 66 && cfg_max != 32'd0) begin
            len = good_len();
            send_header(cfg_magic, cfg_version, cfg_type, len, seq);
            send_noise(len);
            seq_next = seq + 32'd1;
        end else if (pick < 86) begin
            case ($urandom_range(0, 4))
                0: send_header(cfg_magic ^ 32'($urandom_range(1, 32'hFFFF_FFFF)),
                               cfg_version, cfg_type, good_len(), seq);
                1: send_header(cfg_magic, cfg_version ^ 16'($urandom_range(1, 16'hFFFF)),
                               cfg_type, good_len(), seq);
                2: send_header(cfg_magic, cfg_version,
                               cfg_type ^ 16'($urandom_range(1, 16'hFFFF)), good_len(), seq);
                3: send_header(cfg_magic, cfg_version, cfg_type, 32'd0, seq);
                default: begin
                    if (cfg_max > 32'hFFFF_F000)
                        len = 32'hFFFF_FFFF;
                    else if ($urandom_range(0, 1) != 0)
                        len = cfg_max + 32'd1;
                    else
                        len = cfg_max + 32'($urandom_range(2, 1000));
                    send_header(cfg_magic, cfg_version, cfg_type, len, seq);
                end
            endcase
            // dropped bytes until the next connection start
            send_noise($urandom_range(0, 4));
            send_start();
        end else if (pick < 93) begin
            if ($urandom_range(0, 1) != 0 && cfg_max != 32'd0) begin
                if ($urandom_range(0, 3) == 0)
                    len = cfg_max;
                else
                    len = ($urandom % cfg_max) + 32'd1;
                send_header(cfg_magic, cfg_version, cfg_type, len, seq);
                send_noise($urandom_range(0, 4));
            end else begin
                send_noise($urandom_range(1, 15));
            end
            send_start();
        end else begin
            repeat ($urandom_range(2, 12))
                send_item(($urandom_range(0, 3) == 0) ? OP_START : OP_BYTE, 8'($urandom));
            send_start();
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        i_operation  = OP_BYTE;
        i_data_byte  = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_MAGIC;
        i_cfg_data   = '0;
        cycle_count  = 0;
        items_sent   = 0;
        calm         = 1'b1;
        rx_hold_req  = 1'b0;
        rx_hold_left = 0;
        rx_gap       = 0;
        cfg_magic    = RST_MAGIC;
        cfg_version  = RST_VERSION;
        cfg_type     = RST_TYPE;
        cfg_max      = RST_MAX_LEN;
        seq_next     = 32'd0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int p = 0; p < PHASES; p++) begin
            calm = (p % 3 == 0);
            if (p > 0) begin
                wait_drained();
                repeat (6) @(negedge i_clk);
                case (p)
                    1: apply_config(32'h0, 32'hABCD_0000, 32'h1234_0000, 32'd1);
                    2: apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                    3: apply_config($urandom, $urandom, $urandom, 32'd0);
                    default: apply_config($urandom, $urandom, $urandom, $urandom_range(1, 30));
                endcase
            end
            if (p == 0) begin
                // start with nothing in flight, then a cut header
                send_start();
                send_noise(3);
                send_start();
                // first packet never warns, then wrap to zero, then a jump
                send_header(cfg_magic, cfg_version, cfg_type, 32'd1, 32'hFFFF_FFFF);
                send_item(OP_BYTE, 8'hFF);
                send_header(cfg_magic, cfg_version, cfg_type, 32'd2, 32'd0);
                send_item(OP_BYTE, 8'h00);
                send_item(OP_BYTE, 8'hA5);
                send_header(cfg_magic, cfg_version, cfg_type, 32'd1, 32'd5);
                send_item(OP_BYTE, 8'h5A);
                seq_next = 32'd6;
            end
            if (p == 1)
                rx_hold_req = 1'b1;
            while (items_sent < (p + 1) * ITEM_TARGET / PHASES)
                send_random_frame();
        end

        if (push)
            push <= 1'b0;
        wait_drained();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0)
            $display("length_prefixed_frame_deframer_top_tb OK");
        else
            $display("length_prefixed_frame_deframer_top_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lpfd_pkg.sv
rtl/lpfd_front.sv
rtl/lpfd_queue.sv
rtl/length_prefixed_frame_deframer_top.sv
rtl/lpfd_checker.sv
test/lpfd_stream_checker.sv
test/length_prefixed_frame_deframer_top_tb.sv
